// ===== sv/srx_pkg.sv =====
`default_nettype none
package srx_pkg;

  localparam int FRAME_LEN = 25;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam int FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam int MAXF_W     = 4;
  localparam int FAIL_W     = 4;
  localparam logic [3:0] MAXF_RESET = 4'd10;

  localparam logic [7:0] HDR_B0 = 8'h00;
  localparam logic [7:0] HDR_B1 = 8'hAA;
  localparam logic [7:0] HDR_B3 = 8'h55;
  localparam int HDR_LEN = 4;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  localparam logic REG_MAX_FAILURES = 1'b0;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_CRC     = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] frame_byte;
    logic [4:0] byte_index;
    logic       last;
    logic       link_lost;
  } out_item_t;

  // header bytes 0, 1 and 3 are fixed; byte 2 is whatever was received
  function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx,
                                          input logic [7:0] third);
    logic [7:0] val;
    val = HDR_B3;
    if (idx == IDX_W'(0))      val = HDR_B0;
    else if (idx == IDX_W'(1)) val = HDR_B1;
    else if (idx == IDX_W'(2)) val = third;
    return val;
  endfunction

endpackage
`default_nettype wire

// ===== sv/srx_apb_regs.sv =====
`default_nettype none
module srx_apb_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [srx_pkg::MAXF_W-1:0] max_failures
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_failures <= srx_pkg::MAXF_RESET;
    end else if (wr_en && paddr[2] == srx_pkg::REG_MAX_FAILURES) begin
      max_failures <= pwdata[srx_pkg::MAXF_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == srx_pkg::REG_MAX_FAILURES) begin
      prdata = 32'(max_failures);
    end
  end

endmodule
`default_nettype wire

// ===== sv/srx_out_fifo.sv =====
`default_nettype none
module srx_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire srx_pkg::out_item_t  push_item,
  input  wire logic                pop_ready,
  output logic                     out_valid,
  output srx_pkg::out_item_t       out_item,
  output logic [srx_pkg::CNT_W-1:0] count
);

  srx_pkg::out_item_t        slots [srx_pkg::OUT_DEPTH];
  logic [srx_pkg::PTR_W-1:0] wr_ptr;
  logic [srx_pkg::PTR_W-1:0] rd_ptr;
  logic                      pop;

  assign out_valid = (count != '0);
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== sv/srx_ctrl.sv =====
`default_nettype none
module srx_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [7:0]           in_byte,
  input  wire logic [srx_pkg::MAXF_W-1:0] max_failures,
  input  wire logic [srx_pkg::CNT_W-1:0]  fifo_count,
  output logic                      push,
  output srx_pkg::out_item_t        push_item
);

  localparam int IW = srx_pkg::IDX_W;
  localparam int FW = srx_pkg::FILL_W;
  localparam int CNT_W1 = srx_pkg::CNT_W + 1;

  typedef enum logic {ST_RUN, ST_DRAIN} state_t;

  state_t                    state;
  logic [23:0]               header_window;
  logic                      collecting;
  logic [FW-1:0]             fill_count;
  logic [7:0]                running_sum;
  logic [7:0]                hdr_third;
  logic [srx_pkg::FAIL_W-1:0] failure_count;
  logic [IW-1:0]             rd_idx;
  logic [IW-1:0]             rd_idx_q;
  logic                      inflight;

  logic [7:0] frame_store [srx_pkg::FRAME_LEN];
  logic [7:0] mem_rdata;

  logic accept, is_byte, is_timeout, hdr_hit, final_byte, sum_ok;
  logic store_wr, issue, fail_evt;
  logic [srx_pkg::FAIL_W-1:0] fail_inc;
  logic fail_lost;
  srx_pkg::kind_t fail_kind;

  assign accept     = in_valid && in_ready;
  assign is_byte    = accept && in_op == srx_pkg::OP_BYTE;
  assign is_timeout = accept && in_op == srx_pkg::OP_TIMEOUT;
  assign hdr_hit    = fill_count >= FW'(3) && header_window[23:16] == srx_pkg::HDR_B0
                      && header_window[15:8] == srx_pkg::HDR_B1 && in_byte == srx_pkg::HDR_B3;
  assign final_byte = collecting && fill_count == FW'(srx_pkg::FRAME_LEN - 1);
  assign sum_ok     = running_sum == in_byte;
  assign store_wr   = is_byte && collecting;
  assign issue      = state == ST_DRAIN
                      && (CNT_W1'(fifo_count) + CNT_W1'(inflight)) < CNT_W1'(srx_pkg::OUT_DEPTH);

  assign in_ready = state == ST_RUN && !inflight
                    && fifo_count < srx_pkg::CNT_W'(srx_pkg::OUT_DEPTH);

  assign fail_evt  = is_timeout || (is_byte && final_byte && !sum_ok);
  assign fail_kind = is_timeout ? srx_pkg::KIND_TIMEOUT : srx_pkg::KIND_CRC;
  assign fail_inc  = failure_count + 1'b1;
  assign fail_lost = fail_inc >= max_failures || fail_inc == '0;

  always_comb begin
    push      = 1'b0;
    push_item = '0;
    if (inflight) begin
      push                 = 1'b1;
      push_item.kind       = srx_pkg::KIND_BYTE;
      push_item.frame_byte = rd_idx_q < IW'(srx_pkg::HDR_LEN)
                             ? srx_pkg::hdr_byte(rd_idx_q, hdr_third) : mem_rdata;
      push_item.byte_index = 5'(rd_idx_q);
      push_item.last       = rd_idx_q == IW'(srx_pkg::FRAME_LEN - 1);
    end else if (fail_evt) begin
      push                = 1'b1;
      push_item.kind      = fail_kind;
      push_item.last      = 1'b1;
      push_item.link_lost = fail_lost;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      frame_store[fill_count[IW-1:0]] <= in_byte;
    end
    if (issue) begin
      mem_rdata <= frame_store[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      header_window <= '0;
      collecting    <= 1'b0;
      fill_count    <= '0;
      running_sum   <= '0;
      hdr_third     <= '0;
      failure_count <= '0;
      rd_idx        <= '0;
      rd_idx_q      <= '0;
      inflight      <= 1'b0;
    end else begin
      inflight <= issue;
      if (issue) begin
        rd_idx_q <= rd_idx;
        if (rd_idx == IW'(srx_pkg::FRAME_LEN - 1)) begin
          state  <= ST_RUN;
          rd_idx <= '0;
        end else begin
          rd_idx <= rd_idx + 1'b1;
        end
      end

      if (fail_evt) begin
        failure_count <= fail_lost ? '0 : fail_inc;
      end

      if (is_byte) begin
        if (!collecting) begin
          if (hdr_hit) begin
            hdr_third     <= header_window[7:0];
            running_sum   <= srx_pkg::HDR_B0 + srx_pkg::HDR_B1 + header_window[7:0]
                             + srx_pkg::HDR_B3;
            fill_count    <= FW'(srx_pkg::HDR_LEN);
            collecting    <= 1'b1;
            header_window <= '0;
          end else begin
            header_window <= {header_window[15:0], in_byte};
            if (fill_count < FW'(3)) fill_count <= fill_count + 1'b1;
          end
        end else if (final_byte) begin
          collecting    <= 1'b0;
          header_window <= '0;
          fill_count    <= '0;
          running_sum   <= '0;
          if (sum_ok) begin
            failure_count <= '0;
            state         <= ST_DRAIN;
            rd_idx        <= '0;
          end
        end else begin
          running_sum <= running_sum + in_byte;
          fill_count  <= fill_count + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/sync_header_frame_receiver.sv =====
`default_nettype none
// Receives a byte stream (tuser 0) and read-timeout events (tuser 1), hunts for the
// header 00 AA xx 55 and collects 25-byte frames into a frame memory. A frame whose
// 8-bit sum of bytes 0..23 equals byte 24 is read back and sent as 25 beats with
// byte_index 0..24 and tlast on the final beat; a bad sum gives one checksum-failure
// beat and hunting restarts. Timeouts give a timeout-failure beat. Consecutive
// failures are counted; at max_failures (APB register at offset 0, reset 10) the
// failure beat carries link_lost and the count clears. After a good frame the input
// stalls while the frame drains into a four-entry output queue: one frame-memory
// read per cycle while the queue, counting a read in flight, has room.
module sync_header_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] operation
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] frame_byte, [12:8] byte_index, zero fill
  output logic [2:0]       m_tuser,   // [1:0] kind, [2] link_lost
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [srx_pkg::MAXF_W-1:0] max_failures;
  logic [srx_pkg::CNT_W-1:0]  fifo_count;
  logic                       push;
  srx_pkg::out_item_t         push_item;
  srx_pkg::out_item_t         out_item;

  srx_apb_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .max_failures (max_failures)
  );

  srx_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_op        (s_tuser),
    .in_byte      (s_tdata),
    .max_failures (max_failures),
    .fifo_count   (fifo_count),
    .push         (push),
    .push_item    (push_item)
  );

  srx_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop_ready (m_tready),
    .out_valid (m_tvalid),
    .out_item  (out_item),
    .count     (fifo_count)
  );

  assign m_tdata = {3'b000, out_item.byte_index, out_item.frame_byte};
  assign m_tuser = {out_item.link_lost, out_item.kind};
  assign m_tlast = out_item.last;

endmodule
`default_nettype wire

// ===== sv/sync_header_frame_receiver_chk.sv =====
`default_nettype none
module sync_header_frame_receiver_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("output beat changed while stalled");

  a_byte_no_lost: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == srx_pkg::KIND_BYTE |-> !m_tuser[2])
    else $error("link_lost on a frame byte");

  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] != srx_pkg::KIND_BYTE |-> m_tlast && m_tdata == '0)
    else $error("failure beat malformed");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == srx_pkg::KIND_BYTE && m_tlast
    |-> m_tdata[12:8] == 5'(srx_pkg::FRAME_LEN - 1))
    else $error("frame tlast at wrong index");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind sync_header_frame_receiver sync_header_frame_receiver_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== sim/frame_rx_checker.sv =====
`default_nettype none
module frame_rx_checker
  import srx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] operation
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,   // [7:0] frame_byte, [12:8] byte_index
  input  wire logic [2:0]  m_tuser,   // [1:0] kind, [2] link_lost
  input  wire logic        m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               mismatches,
  output int               beats_due_count
);

  localparam logic [2:0] MAXF_ADDR = 3'(4 * REG_MAX_FAILURES);

  out_item_t   beats_due[$];
  logic [23:0] window;
  logic        collecting;
  logic [7:0]  frame_mem [FRAME_LEN];
  int          fill;
  logic [7:0]  sum;
  logic [3:0]  fail_run;
  logic [3:0]  fail_limit;

  initial begin
    mismatches = 0;
    beats_due_count = 0;
    fail_limit = MAXF_RESET;
    fail_run = '0;
  end

  task automatic restart_hunt();
    collecting = 1'b0;
    window = '0;
    fill = 0;
    sum = '0;
  endtask

  task automatic note_failure(input kind_t k);
    out_item_t beat;
    beat = '0;
    beat.kind = k;
    beat.last = 1'b1;
    fail_run = fail_run + 4'd1;
    if (fail_run >= fail_limit || fail_run == 4'd0) begin
      beat.link_lost = 1'b1;
      fail_run = '0;
    end
    beats_due.push_back(beat);
  endtask

  task automatic absorb_item(input logic op, input logic [7:0] rx);
    out_item_t beat;
    if (op == OP_TIMEOUT) begin
      // a timeout never disturbs the hunt window or a partial frame
      note_failure(KIND_TIMEOUT);
    end else if (!collecting) begin
      if (fill >= 3 && window[23:16] == HDR_B0 && window[15:8] == HDR_B1 && rx == HDR_B3) begin
        frame_mem[0] = HDR_B0;
        frame_mem[1] = HDR_B1;
        frame_mem[2] = window[7:0];
        frame_mem[3] = rx;
        sum = HDR_B0 + HDR_B1 + window[7:0] + rx;
        fill = HDR_LEN;
        collecting = 1'b1;
        window = '0;
      end else begin
        window = {window[15:0], rx};
        if (fill < 3) fill++;
      end
    end else begin
      if (fill < FRAME_LEN) begin
        frame_mem[fill] = rx;
        if (fill < FRAME_LEN - 1) sum = sum + rx;
        fill++;
      end
      if (fill == FRAME_LEN) begin
        if (sum == frame_mem[FRAME_LEN-1]) begin
          for (int i = 0; i < FRAME_LEN; i++) begin
            beat = '0;
            beat.kind = KIND_BYTE;
            beat.frame_byte = frame_mem[i];
            beat.byte_index = 5'(i);
            beat.last = (i == FRAME_LEN - 1);
            beats_due.push_back(beat);
          end
          fail_run = '0;
          restart_hunt();
        end else begin
          restart_hunt();
          note_failure(KIND_CRC);
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_item_t got;
    out_item_t want;
    if (rst) begin
      restart_hunt();
      fail_run = '0;
      fail_limit = MAXF_RESET;
      beats_due.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MAXF_ADDR)
        fail_limit = pwdata[3:0];
      if (s_tvalid && s_tready)
        absorb_item(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind = kind_t'(m_tuser[1:0]);
        got.frame_byte = m_tdata[7:0];
        got.byte_index = m_tdata[12:8];
        got.last = m_tlast;
        got.link_lost = m_tuser[2];
        if (beats_due.size() == 0) begin
          $error("unexpected beat kind %0d byte %0d index %0d",
                 got.kind, got.frame_byte, got.byte_index);
          mismatches++;
        end else begin
          want = beats_due.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind expected %0d got %0d", want.kind, got.kind);
            mismatches++;
          end
          if (got.frame_byte !== want.frame_byte) begin
            $error("frame_byte expected %0d got %0d", want.frame_byte, got.frame_byte);
            mismatches++;
          end
          if (got.byte_index !== want.byte_index) begin
            $error("byte_index expected %0d got %0d", want.byte_index, got.byte_index);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $error("last expected %0d got %0d", want.last, got.last);
            mismatches++;
          end
          if (got.link_lost !== want.link_lost) begin
            $error("link_lost expected %0d got %0d", want.link_lost, got.link_lost);
            mismatches++;
          end
        end
      end
    end
    beats_due_count = beats_due.size();
  end

endmodule
`default_nettype wire

// ===== sim/sync_header_frame_receiver_tb.sv =====
`default_nettype none
module sync_header_frame_receiver_tb;
  import srx_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 500;
  localparam int SETTLE       = 40;
  localparam logic [2:0] MAXF_ADDR = 3'(4 * REG_MAX_FAILURES);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = OP_BYTE;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int   mismatches;
  int   beats_due_count;
  int   cycle_count = 0;
  int   sent = 0;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;
  int   limit_now = MAXF_RESET;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sync_header_frame_receiver u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  frame_rx_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata),
    .mismatches(mismatches), .beats_due_count(beats_due_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // output side: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= !(idle_on && $urandom_range(99) < 27);
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] data);
    while (idle_on && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(3))
      0: return HDR_B0;
      1: return HDR_B1;
      2: return HDR_B3;
      default: return 8'($urandom);
    endcase
  endfunction

  // gap_at < 0: no timeout inside the frame
  task automatic send_frame(input logic [7:0] third, input bit good, input int gap_at);
    logic [7:0] body [FRAME_LEN];
    logic [7:0] sum;
    sum = '0;
    body[0] = HDR_B0;
    body[1] = HDR_B1;
    body[2] = third;
    body[3] = HDR_B3;
    for (int i = HDR_LEN; i < FRAME_LEN - 1; i++) body[i] = 8'($urandom);
    for (int i = 0; i < FRAME_LEN - 1; i++) sum = sum + body[i];
    body[FRAME_LEN-1] = good ? sum : sum ^ 8'(1 << $urandom_range(7));
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (i == gap_at) send_beat(OP_TIMEOUT, 8'($urandom));
      send_beat(OP_BYTE, body[i]);
    end
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (beats_due_count != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_max_failures(input logic [3:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= MAXF_ADDR;
    pwdata <= {28'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_now = value;
  endtask

  task automatic run_traffic(input int items);
    int stop_at;
    int pick;
    stop_at = sent + items;
    while (sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        repeat ($urandom_range(2)) send_beat(OP_BYTE, noise_byte());
        send_frame(8'($urandom), $urandom_range(3) != 0,
                   ($urandom_range(4) == 0) ? int'($urandom_range(FRAME_LEN - 1, 1)) : -1);
      end else if (pick < 80) begin
        repeat ($urandom_range(4, 1)) send_beat(OP_BYTE, noise_byte());
      end else begin
        repeat ($urandom_range(limit_now + 1, 1)) send_beat(OP_TIMEOUT, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // a cleared window must not stand in for a leading zero byte
    send_beat(OP_BYTE, HDR_B1);
    send_beat(OP_BYTE, 8'h3C);
    send_beat(OP_BYTE, HDR_B3);
    send_beat(OP_BYTE, 8'hFF);
    send_beat(OP_TIMEOUT, 8'h00);
    // good frame with a timeout in the middle of collection
    send_frame(8'hFF, 1'b1, 10);

    // output held off while good frames keep coming
    hold_req = 1'b1;
    repeat (2) send_frame(8'($urandom), 1'b1, -1);
    wait_quiet();

    write_max_failures(4'd1);
    run_traffic(10);
    wait_quiet();

    write_max_failures(4'd15);
    repeat (16) send_beat(OP_TIMEOUT, 8'($urandom));
    wait_quiet();

    idle_on = 1'b0;
    write_max_failures(4'd0);
    send_frame(8'($urandom), 1'b0, -1);
    wait_quiet();

    idle_on = 1'b1;
    write_max_failures(4'($urandom_range(15, 1)));
    run_traffic(10);

    s_tvalid <= 1'b0;
    while (beats_due_count != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
